/* sv/rpd_pkg.sv */
// shared types, constants and codes of the radio packet deframer
package rpd_pkg;

    localparam int HEADER_BYTES             = 10;
    localparam int LENGTH_BASE              = 9;
    localparam int DBM_BASE                 = 74;
    localparam int DEFAULT_MAX_PACKET_BYTES = 200;
    localparam int BYTE_SAT                 = 255;

    // result queue, depth a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_LONG     = 2'd2,
        STATUS_MISMATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  msg_counter;
        logic [7:0]  msg_subtype;
        logic [7:0]  msg_type;
        logic [23:0] sender;
        logic [23:0] dest;
        logic [7:0]  signal_level;
        logic        rssi_valid;
        status_t     status;
        logic        end_of_run;
    } result_t;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

/* sv/rpd_parse.sv */
// per-byte packet state and result generation
module rpd_parse #(
    parameter int MAX_PACKET_BYTES = rpd_pkg::DEFAULT_MAX_PACKET_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  logic [7:0]    item_byte,
    input  logic          item_last,
    input  logic          rssi_present,
    output rpd_pkg::push_t push
);
    import rpd_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  counter_reg, counter_next;
    logic [7:0]  subtype_reg, subtype_next;
    logic [7:0]  type_reg, type_next;
    logic [23:0] sender_reg, sender_next;
    logic [23:0] dest_reg, dest_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic [7:0]  payload_count_reg, payload_count_next;
    logic        rssi_mode_reg, rssi_mode_next;

    logic        mode;
    logic        in_payload;
    logic        emit;
    logic [7:0]  emit_value;
    logic [8:0]  rssi_wide;
    logic [8:0]  rssi_half;
    logic [8:0]  dbm_wide;
    logic        dbm_valid;
    status_t     status;
    result_t     payload_res;
    result_t     summary_res;

    always_comb
    begin
        mode = (pos_reg == 8'd0) ? rssi_present : rssi_mode_reg;
        in_payload = (pos_reg >= 8'(HEADER_BYTES));

        length_next  = length_reg;
        counter_next = counter_reg;
        subtype_next = subtype_reg;
        type_next    = type_reg;
        sender_next  = sender_reg;
        dest_next    = dest_reg;
        unique case (pos_reg)
            8'd0:                 length_next  = item_byte;
            8'd1:                 counter_next = item_byte;
            8'd2:                 subtype_next = item_byte;
            8'd3:                 type_next    = item_byte;
            8'd4, 8'd5, 8'd6:     sender_next  = {sender_reg[15:0], item_byte};
            8'd7, 8'd8, 8'd9:     dest_next    = {dest_reg[15:0], item_byte};
            default:              ;
        endcase

        // rssi mode holds each payload byte back by one so the last can be rssi
        emit            = 1'b0;
        emit_value      = item_byte;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        dbm_valid       = 1'b0;
        if (in_payload)
        begin
            if (mode)
            begin
                emit            = held_valid_reg;
                emit_value      = held_byte_reg;
                held_byte_next  = item_byte;
                held_valid_next = !item_last;
                dbm_valid       = item_last;
            end
            else
            begin
                emit = 1'b1;
            end
        end

        payload_count_next = payload_count_reg;
        if (emit && (payload_count_reg != 8'(BYTE_SAT)))
        begin
            payload_count_next = payload_count_reg + 8'd1;
        end

        pos_next = (pos_reg != 8'(BYTE_SAT)) ? pos_reg + 8'd1 : pos_reg;
        rssi_mode_next = mode;

        // signed byte halved towards zero
        rssi_wide = {item_byte[7], item_byte};
        rssi_half = 9'($signed(rssi_wide + {8'd0, item_byte[7]}) >>> 1);
        dbm_wide  = 9'(DBM_BASE) - rssi_half;

        priority if (pos_reg < 8'(HEADER_BYTES - 1))
            status = STATUS_SHORT;
        else if (pos_reg >= 8'(MAX_PACKET_BYTES))
            status = STATUS_LONG;
        else if ({1'b0, length_next} != (9'(LENGTH_BASE) + {1'b0, payload_count_next}))
            status = STATUS_MISMATCH;
        else
            status = STATUS_OK;

        payload_res              = '0;
        payload_res.kind         = KIND_PAYLOAD;
        payload_res.payload_byte = emit_value;
        payload_res.status       = STATUS_OK;

        summary_res              = '0;
        summary_res.kind         = KIND_SUMMARY;
        summary_res.msg_counter  = counter_next;
        summary_res.msg_subtype  = subtype_next;
        summary_res.msg_type     = type_next;
        summary_res.sender       = sender_next;
        summary_res.dest         = dest_next;
        summary_res.signal_level = dbm_valid ? dbm_wide[7:0] : 8'd0;
        summary_res.rssi_valid   = dbm_valid;
        summary_res.status       = status;
        summary_res.end_of_run   = 1'b1;

        push.count  = item_valid ? (2'({1'b0, emit}) + 2'({1'b0, item_last})) : 2'd0;
        push.first  = emit ? payload_res : summary_res;
        push.second = summary_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            length_reg        <= '0;
            counter_reg       <= '0;
            subtype_reg       <= '0;
            type_reg          <= '0;
            sender_reg        <= '0;
            dest_reg          <= '0;
            held_byte_reg     <= '0;
            held_valid_reg    <= 1'b0;
            payload_count_reg <= '0;
            rssi_mode_reg     <= 1'b0;
        end
        else if (item_valid)
        begin
            if (item_last)
            begin
                pos_reg           <= '0;
                length_reg        <= '0;
                counter_reg       <= '0;
                subtype_reg       <= '0;
                type_reg          <= '0;
                sender_reg        <= '0;
                dest_reg          <= '0;
                held_byte_reg     <= '0;
                held_valid_reg    <= 1'b0;
                payload_count_reg <= '0;
                rssi_mode_reg     <= 1'b0;
            end
            else
            begin
                pos_reg           <= pos_next;
                length_reg        <= length_next;
                counter_reg       <= counter_next;
                subtype_reg       <= subtype_next;
                type_reg          <= type_next;
                sender_reg        <= sender_next;
                dest_reg          <= dest_next;
                held_byte_reg     <= held_byte_next;
                held_valid_reg    <= held_valid_next;
                payload_count_reg <= payload_count_next;
                rssi_mode_reg     <= rssi_mode_next;
            end
        end
    end

endmodule

/* sv/rpd_result_fifo.sv */
// small result queue taking up to two results a cycle, giving one
module rpd_result_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  rpd_pkg::push_t  push,
    input  logic            pop,
    output rpd_pkg::result_t head,
    output logic            not_empty,
    output logic            has_room
);
    import rpd_pkg::*;

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_second;

    assign not_empty     = (count_reg != '0);
    assign has_room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign head          = mem_reg[rd_ptr_reg];
    assign wr_ptr_second = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/radio_packet_deframer.sv */
// top level of the radio packet deframer: input register, parser, result queue
// path: an accepted byte is held in the input register, then parsed, and its results are written into the queue
// throughput: one byte per cycle, taken by the parser from its input register while the queue has room for two
// output rate: one result per cycle while out_stall is low; a last byte that also releases payload makes two
// reset: rst_n asynchronous active low clears packet state, queue and rssi_present
module radio_packet_deframer #(
    parameter int MAX_PACKET_BYTES = rpd_pkg::DEFAULT_MAX_PACKET_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  msg_counter,
    output logic [7:0]  msg_subtype,
    output logic [7:0]  msg_type,
    output logic [23:0] sender,
    output logic [23:0] dest,
    output logic [7:0]  signal_level,
    output logic        rssi_valid,
    output logic [1:0]  status,
    output logic        end_of_run,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import rpd_pkg::*;

    // input register
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_byte_reg;
    logic       stage_last_reg;
    logic       rssi_present_reg;

    logic       in_accept;
    logic       advance;
    logic       queue_room;
    logic       queue_not_empty;
    push_t      push;
    result_t    head;

    // the register is always writable, it is only sampled at a packet's first byte
    assign cfg_ready = 1'b1;

    // the held item moves into the parser once the queue can take two results
    assign advance   = stage_valid_reg && queue_room;
    assign in_stall  = stage_valid_reg && !queue_room;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            rssi_present_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                rssi_present_reg <= cfg_data;
            end
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_byte_reg <= data_byte;
            stage_last_reg <= last_byte;
        end
    end

    rpd_parse #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (advance),
        .item_byte    (stage_byte_reg),
        .item_last    (stage_last_reg),
        .rssi_present (rssi_present_reg),
        .push         (push)
    );

    // queue separates the parser from a stalled consumer
    rpd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_valid && !out_stall),
        .head      (head),
        .not_empty (queue_not_empty),
        .has_room  (queue_room)
    );

    assign out_valid    = queue_not_empty;
    assign kind         = head.kind;
    assign payload_byte = head.payload_byte;
    assign msg_counter  = head.msg_counter;
    assign msg_subtype  = head.msg_subtype;
    assign msg_type     = head.msg_type;
    assign sender       = head.sender;
    assign dest         = head.dest;
    assign signal_level = head.signal_level;
    assign rssi_valid   = head.rssi_valid;
    assign status       = head.status;
    assign end_of_run   = head.end_of_run;

endmodule

/* sv/rpd_checker.sv */
// port-level checks of the radio packet deframer and their binding
module rpd_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        kind,
    input logic [7:0]  payload_byte,
    input logic [7:0]  msg_counter,
    input logic [23:0] sender,
    input logic [23:0] dest,
    input logic [7:0]  signal_level,
    input logic        rssi_valid,
    input logic [1:0]  status,
    input logic        end_of_run
);
    import rpd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_byte)
            && $stable(status) && $stable(end_of_run))
        else $error("stalled result changed");

    // only the summary closes a packet
    a_summary_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_SUMMARY) == end_of_run)
        else $error("end_of_run does not match kind");

    // payload results carry no header or rssi
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PAYLOAD) |-> msg_counter == 8'd0 && sender == 24'd0
            && dest == 24'd0 && !rssi_valid && status == STATUS_OK)
        else $error("payload result carries summary fields");

    // rssi value within its range when decoded, zero otherwise
    a_rssi_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rssi_valid && signal_level >= 8'd11 && signal_level <= 8'd138)
            || (!rssi_valid && signal_level == 8'd0))
        else $error("rssi value out of range");

endmodule

bind radio_packet_deframer rpd_port_checks u_rpd_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .msg_counter  (msg_counter),
    .sender       (sender),
    .dest         (dest),
    .signal_level (signal_level),
    .rssi_valid   (rssi_valid),
    .status       (status),
    .end_of_run   (end_of_run)
);

/* bench/rpd_checker.sv */
// checker for the radio packet deframer: watches the channels, predicts results and compares
`timescale 1ns / 1ps

module rpd_checker #(
    parameter int PACKET_LIMIT = rpd_pkg::DEFAULT_MAX_PACKET_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        kind,
    input  logic [7:0]  payload_byte,
    input  logic [7:0]  msg_counter,
    input  logic [7:0]  msg_subtype,
    input  logic [7:0]  msg_type,
    input  logic [23:0] sender,
    input  logic [23:0] dest,
    input  logic [7:0]  signal_level,
    input  logic        rssi_valid,
    input  logic [1:0]  status,
    input  logic        end_of_run,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          fail_count,
    output int          outstanding
);
    import rpd_pkg::*;

    result_t due_results[$];
    int      mismatches = 0;

    // packet state of the prediction
    logic        rssi_cfg;
    logic        rssi_mode;
    logic [7:0]  byte_pos;
    logic [7:0]  len_byte;
    logic [7:0]  ctr_byte;
    logic [7:0]  sub_byte;
    logic [7:0]  typ_byte;
    logic [23:0] src_addr;
    logic [23:0] dst_addr;
    logic [7:0]  held_byte;
    logic        held_ok;
    logic [7:0]  paid_count;

    task report(input string what);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    task check_field(input string name, input logic [23:0] seen, input logic [23:0] want);
        if (seen !== want)
        begin
            report($sformatf("%s is %0h, %0h predicted", name, seen, want));
        end
    endtask

    task clear_packet();
        rssi_mode  = 1'b0;
        byte_pos   = '0;
        len_byte   = '0;
        ctr_byte   = '0;
        sub_byte   = '0;
        typ_byte   = '0;
        src_addr   = '0;
        dst_addr   = '0;
        held_byte  = '0;
        held_ok    = 1'b0;
        paid_count = '0;
    endtask

    task push_payload(input logic [7:0] value);
        result_t r;
        r              = '0;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = value;
        due_results    = {due_results, r};
        if (paid_count != BYTE_SAT)
        begin
            paid_count++;
        end
    endtask

    // one accepted byte: header capture, payload release, rssi decode, summary
    task deframe_byte(input logic [7:0] b, input logic is_last);
        result_t    r;
        int         total;
        int         signed_rssi;
        logic [7:0] dbm;
        logic       dbm_ok;
        status_t    st;
        dbm    = '0;
        dbm_ok = 1'b0;
        if (byte_pos == 0)
        begin
            rssi_mode = rssi_cfg;
        end
        case (byte_pos)
            8'd0: len_byte = b;
            8'd1: ctr_byte = b;
            8'd2: sub_byte = b;
            8'd3: typ_byte = b;
            8'd4, 8'd5, 8'd6: src_addr = {src_addr[15:0], b};
            8'd7, 8'd8, 8'd9: dst_addr = {dst_addr[15:0], b};
            default: ;
        endcase
        if (byte_pos >= HEADER_BYTES)
        begin
            if (rssi_mode)
            begin
                if (held_ok)
                begin
                    push_payload(held_byte);
                    held_ok = 1'b0;
                end
                if (!is_last)
                begin
                    held_byte = b;
                    held_ok   = 1'b1;
                end
                else
                begin
                    signed_rssi = $signed(b);
                    dbm         = 8'(DBM_BASE - signed_rssi / 2);
                    dbm_ok      = 1'b1;
                end
            end
            else
            begin
                push_payload(b);
            end
        end
        total = int'(byte_pos) + 1;
        if (byte_pos != BYTE_SAT)
        begin
            byte_pos++;
        end
        if (is_last)
        begin
            if (total < HEADER_BYTES)
                st = STATUS_SHORT;
            else if (total > PACKET_LIMIT)
                st = STATUS_LONG;
            else if (int'(len_byte) != LENGTH_BASE + int'(paid_count))
                st = STATUS_MISMATCH;
            else
                st = STATUS_OK;
            r              = '0;
            r.kind         = KIND_SUMMARY;
            r.msg_counter  = ctr_byte;
            r.msg_subtype  = sub_byte;
            r.msg_type     = typ_byte;
            r.sender       = src_addr;
            r.dest         = dst_addr;
            r.signal_level = dbm;
            r.rssi_valid   = dbm_ok;
            r.status       = st;
            r.end_of_run   = 1'b1;
            due_results    = {due_results, r};
            clear_packet();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            due_results.delete();
            rssi_cfg = 1'b0;
            clear_packet();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {kind, payload_byte, msg_counter, msg_subtype, msg_type, sender, dest,
                       signal_level, rssi_valid, status_t'(status), end_of_run};
                if (due_results.size() == 0)
                begin
                    report("result arrived with nothing predicted");
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", got.kind, want.kind);
                    check_field("payload_byte", got.payload_byte, want.payload_byte);
                    check_field("msg_counter", got.msg_counter, want.msg_counter);
                    check_field("msg_subtype", got.msg_subtype, want.msg_subtype);
                    check_field("msg_type", got.msg_type, want.msg_type);
                    check_field("sender", got.sender, want.sender);
                    check_field("dest", got.dest, want.dest);
                    check_field("signal_level", got.signal_level, want.signal_level);
                    check_field("rssi_valid", got.rssi_valid, want.rssi_valid);
                    check_field("status", got.status, want.status);
                    check_field("end_of_run", got.end_of_run, want.end_of_run);
                end
            end
            if (in_valid && !in_stall)
            begin
                deframe_byte(data_byte, last_byte);
            end
            if (cfg_valid && cfg_ready)
            begin
                rssi_cfg = cfg_data;
            end
        end
        fail_count  <= mismatches;
        outstanding <= due_results.size();
    end

endmodule

/* bench/tb.sv */
// top of the radio packet deframer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import rpd_pkg::*;

    // generous bound on the whole run, far above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;
    // items per random phase, not counting the long packets
    localparam int PHASE_ITEMS = 10;
    // length of the one long receiver hold-off
    localparam int HOLD_CYCLES = 80;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_MISMATCH,
        SHAPE_NOISE
    } shape_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  msg_counter;
    logic [7:0]  msg_subtype;
    logic [7:0]  msg_type;
    logic [23:0] sender;
    logic [23:0] dest;
    logic [7:0]  signal_level;
    logic        rssi_valid;
    logic [1:0]  status;
    logic        end_of_run;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    int fail_count;
    int outstanding;
    int cycles = 0;

    // sender bookkeeping
    int   items_sent = 0;
    int   burst_left = 0;
    logic rssi_setting = 1'b0;

    // receiver hold-off request, raised once by the stimulus
    logic long_hold_req  = 1'b0;
    logic long_hold_done = 1'b0;

    // signed rssi corners: most negative and one above it, most positive, and -1, 0, +1 around zero
    logic [7:0] rssi_corner [6] = '{8'h80, 8'h7f, 8'hff, 8'h81, 8'h00, 8'h01};

    // directed packets: all ones and all zeros spread over the header fields
    logic [7:0] corner_plain [11] = '{8'h0a, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
                                      8'h00, 8'h00, 8'h00, 8'hff};
    logic [7:0] corner_rssi [10]  = '{8'h09, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
                                      8'hff, 8'hff, 8'hff};

    always #5 clk = ~clk;

    radio_packet_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .msg_counter  (msg_counter),
        .msg_subtype  (msg_subtype),
        .msg_type     (msg_type),
        .sender       (sender),
        .dest         (dest),
        .signal_level (signal_level),
        .rssi_valid   (rssi_valid),
        .status       (status),
        .end_of_run   (end_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    rpd_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .msg_counter  (msg_counter),
        .msg_subtype  (msg_subtype),
        .msg_type     (msg_type),
        .sender       (sender),
        .dest         (dest),
        .signal_level (signal_level),
        .rssi_valid   (rssi_valid),
        .status       (status),
        .end_of_run   (end_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("radio_packet_deframer verification failed");
            $finish;
        end
    end

    // offer one byte and hold it until taken; bursts of random length with
    // random gaps in front of them, some bursts start with no gap at all
    task send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        burst_left--;
        items_sent++;
    endtask

    // one whole packet of the given size under the current rssi setting
    task send_packet(input int total, input shape_t shape);
        int         pay;
        int         i;
        logic [7:0] len_ok;
        logic [7:0] b;
        pay = total - HEADER_BYTES - ((rssi_setting && total > HEADER_BYTES) ? 1 : 0);
        if (pay < 0)
        begin
            pay = 0;
        end
        len_ok = 8'(LENGTH_BASE + pay);
        for (i = 0; i < total; i++)
        begin
            if (i == 0)
            begin
                case (shape)
                    SHAPE_GOOD:     b = len_ok;
                    SHAPE_MISMATCH: b = len_ok + 8'($urandom_range(1, 255));
                    default:        b = 8'($urandom_range(0, 255));
                endcase
            end
            else if (i == total - 1 && rssi_setting && i >= HEADER_BYTES)
            begin
                // rssi byte, biased towards the signed corners
                if ($urandom_range(0, 3) == 0)
                    b = rssi_corner[$urandom_range(0, 5)];
                else
                    b = 8'($urandom_range(0, 255));
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
            end
            send_byte(b, i == total - 1);
        end
    endtask

    // stop sending and wait for every predicted result, then let the
    // pipeline settle before anything touches the register
    task settle();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task write_rssi(input logic value);
        rssi_setting = value;
        cfg_valid   <= 1'b1;
        cfg_data    <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // receiver: stall style changes every segment, one long hold-off on request
    initial
    begin
        int seg;
        int style;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            seg   = $urandom_range(10, 80);
            style = $urandom_range(0, 3);
            repeat (seg)
            begin
                @(posedge clk);
                if (long_hold_req && !long_hold_done)
                begin
                    // long hold: the result queue fills and the input stalls
                    long_hold_done = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                else
                begin
                    case (style)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 99) < 30);
                        2: out_stall <= ($urandom_range(0, 99) < 70);
                        default: out_stall <= ~out_stall;
                    endcase
                end
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int     i;
        int     ph;
        int     phase_start;
        int     pick;
        shape_t shape;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= '0;
        last_byte <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, rssi off: full packet with header corners, then a
        // one-byte packet that ends inside the header
        write_rssi(1'b0);
        for (i = 0; i < 11; i++)
        begin
            send_byte(corner_plain[i], i == 10);
        end
        send_byte(8'h55, 1'b1);
        settle();

        // rssi on: ten-byte packet, so no rssi byte and an expected length of nine
        write_rssi(1'b1);
        for (i = 0; i < 10; i++)
        begin
            send_byte(corner_rssi[i], i == 9);
        end
        settle();

        // random phases, each under its own register setting
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_rssi(1'b0);
                1: write_rssi(1'b1);
                2: write_rssi(1'b0);
                default: write_rssi(1'($urandom_range(0, 1)));
            endcase
            // around the size limit, and far past it so the byte position saturates and the payload count may too
            if (ph == 1)
            begin
                send_packet($urandom_range(198, 203), SHAPE_GOOD);
            end
            if (ph == 3)
            begin
                send_packet($urandom_range(262, 280), SHAPE_GOOD);
            end
            if (ph == 2)
            begin
                long_hold_req = 1'b1;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    shape = SHAPE_GOOD;
                    send_packet(HEADER_BYTES + $urandom_range(0, 12), shape);
                end
                else if (pick < 80)
                begin
                    shape = SHAPE_GOOD;
                    send_packet($urandom_range(1, HEADER_BYTES - 1), shape);
                end
                else if (pick < 90)
                begin
                    shape = SHAPE_MISMATCH;
                    send_packet($urandom_range(HEADER_BYTES, 30), shape);
                end
                else
                begin
                    shape = SHAPE_NOISE;
                    send_packet($urandom_range(1, 30), shape);
                end
            end
            settle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("radio_packet_deframer verification clean");
        end
        else
        begin
            $display("radio_packet_deframer verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/rpd_pkg.sv
sv/rpd_parse.sv
sv/rpd_result_fifo.sv
sv/radio_packet_deframer.sv
sv/rpd_checker.sv
bench/rpd_checker.sv
bench/tb.sv
